// ----- hdl/i2cms_pkg.sv -----
// Shared types and codes for the I2C master transaction sequencer.
package i2cms_pkg;

   // request operations
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_EVENT = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_BYTE_COUNT    = 2'd1;
   localparam logic [1:0] CSR_READ_MODE     = 2'd2;

   // bus action codes on the result channel
   localparam logic [2:0] BUS_NONE  = 3'd0;
   localparam logic [2:0] BUS_START = 3'd1;
   localparam logic [2:0] BUS_LOAD  = 3'd2;
   localparam logic [2:0] BUS_ACK   = 3'd3;
   localparam logic [2:0] BUS_NACK  = 3'd4;
   localparam logic [2:0] BUS_STOP  = 3'd5;

   // error codes
   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_START   = 3'd1;
   localparam logic [2:0] ERR_ADDR_W  = 3'd2;
   localparam logic [2:0] ERR_ADDR_R  = 3'd3;
   localparam logic [2:0] ERR_DATA_TX = 3'd4;
   localparam logic [2:0] ERR_ACK_RX  = 3'd5;
   localparam logic [2:0] ERR_NACK_RX = 3'd6;
   localparam logic [2:0] ERR_PARAM   = 3'd7;

   // bus status codes
   localparam logic [7:0] CODE_MASK     = 8'hF8;
   localparam logic [7:0] ST_NO_INFO    = 8'hF8;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
   localparam logic [7:0] ST_DATA_SENT  = 8'h28;
   localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
   localparam logic [7:0] ST_RX_ACK     = 8'h50;
   localparam logic [7:0] ST_RX_NACK    = 8'h58;

   // sequence phases
   typedef enum logic [2:0] {
      PH_START   = 3'd0,
      PH_ADDR_W  = 3'd1,
      PH_ADDR_R  = 3'd2,
      PH_DATA_TX = 3'd3,
      PH_RX_ACK  = 3'd4,
      PH_RX_NACK = 3'd5
   } phase_type;

   // last ordered sequencer action
   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_ADDR_W = 3'd1,
      ACT_ADDR_R = 3'd2,
      ACT_DATA   = 3'd3,
      ACT_ACK    = 3'd4,
      ACT_NACK   = 3'd5,
      ACT_STOP   = 3'd6
   } seq_act_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] bus_status;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] data_out;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic [2:0] error_code;
      logic [7:0] captured_status;
      logic       stop_issued;
   } rsp_item_type;

   typedef struct packed {
      logic       wr_en;
      logic [1:0] index;
      logic [7:0] wdata;
   } csr_write_type;

endpackage

// ----- hdl/i2cms_if.sv -----
// Request and result channel interfaces of the I2C master sequencer.
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] bus_status;
   logic [7:0] rx_byte;
   logic [7:0] tx_byte;

   modport source (output valid, operation, bus_status, rx_byte, tx_byte, input ready);
   modport sink   (input valid, operation, bus_status, rx_byte, tx_byte, output ready);
endinterface

interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_action;
   logic [7:0] data_out;
   logic       rx_valid;
   logic [7:0] rx_data;
   logic [2:0] error_code;
   logic [7:0] captured_status;
   logic       stop_issued;

   modport source (output valid, bus_action, data_out, rx_valid, rx_data, error_code,
                   captured_status, stop_issued, input ready);
   modport sink   (input valid, bus_action, data_out, rx_valid, rx_data, error_code,
                   captured_status, stop_issued, output ready);
   modport mon    (input valid, ready, bus_action, data_out, rx_valid, rx_data, error_code,
                   captured_status, stop_issued);
endinterface

// ----- hdl/i2cms_req_stage.sv -----
// Input register for incoming requests.
module i2cms_req_stage
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_take,
   output req_item_type out_item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   // accept while empty or while the held request moves on
   assign in_ready = !valid_ff || out_take;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture request payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hdl/i2cms_seq_core.sv -----
// Transaction sequencer state, configuration registers and result logic.
module i2cms_seq_core
   import i2cms_pkg::*;
#(
   parameter int MAX_BYTES = 255
) (
   input  logic          clock,
   input  logic          reset,
   input  csr_write_type csr,
   input  logic          fire,
   input  req_item_type  item,
   output rsp_item_type  result
);

   localparam logic [7:0] MaxCount = 8'(MAX_BYTES);

   // configuration registers
   logic [6:0] slave_address_ff;
   logic [7:0] byte_count_ff;
   logic       read_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= 7'd0;
         byte_count_ff    <= 8'd1;
         read_mode_ff     <= 1'b0;
      end else if (csr.wr_en) begin
         case (csr.index)
            CSR_SLAVE_ADDRESS: slave_address_ff <= csr.wdata[6:0];
            CSR_BYTE_COUNT:    byte_count_ff    <= csr.wdata;
            CSR_READ_MODE:     read_mode_ff     <= csr.wdata[0];
            default: ;
         endcase
      end
   end

   // sequence state
   phase_type   phase_ff, phase_in;
   logic [8:0]  index_ff, index_in;
   logic [2:0]  error_ff, error_in;
   logic [7:0]  status_ff, status_in;
   logic        stopped_ff, stopped_in;
   seq_act_type last_act_ff, last_act_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_START;
         index_ff    <= 9'd1;
         error_ff    <= ERR_OK;
         status_ff   <= ST_NO_INFO;
         stopped_ff  <= 1'b0;
         last_act_ff <= ACT_NONE;
      end else begin
         phase_ff    <= phase_in;
         index_ff    <= index_in;
         error_ff    <= error_in;
         status_ff   <= status_in;
         stopped_ff  <= stopped_in;
         last_act_ff <= last_act_in;
      end
   end

   logic [7:0]  code;
   logic [7:0]  expect_code;
   logic [2:0]  phase_err;
   logic        known;
   logic        match;
   logic        bad_count;
   logic [9:0]  n10, i10;
   logic        br_taken, br_step;
   seq_act_type br_act;
   phase_type   br_phase;
   seq_act_type act_sel;

   // check the status against the phase and pick the branch
   always_comb begin
      code      = item.bus_status & CODE_MASK;
      bad_count = (byte_count_ff == 8'd0) || (byte_count_ff > MaxCount);
      n10       = 10'(byte_count_ff);
      i10       = 10'(index_ff);

      known       = 1'b1;
      expect_code = 8'd0;
      phase_err   = ERR_PARAM;
      case (phase_ff)
         PH_START:   begin expect_code = ST_START;      phase_err = ERR_START;   end
         PH_ADDR_W:  begin expect_code = ST_ADDR_W_ACK; phase_err = ERR_ADDR_W;  end
         PH_ADDR_R:  begin expect_code = ST_ADDR_R_ACK; phase_err = ERR_ADDR_R;  end
         PH_DATA_TX: begin expect_code = ST_DATA_SENT;  phase_err = ERR_DATA_TX; end
         PH_RX_ACK:  begin expect_code = ST_RX_ACK;     phase_err = ERR_ACK_RX;  end
         PH_RX_NACK: begin expect_code = ST_RX_NACK;    phase_err = ERR_NACK_RX; end
         default:    known = 1'b0;
      endcase
      match = known && (code == expect_code);

      br_taken = 1'b0;
      br_step  = 1'b0;
      br_act   = ACT_NONE;
      br_phase = phase_ff;
      case (phase_ff)
         PH_START: begin
            if (i10 == 10'd1) begin
               br_taken = 1'b1;
               br_step  = 1'b1;
               br_act   = read_mode_ff ? ACT_ADDR_R : ACT_ADDR_W;
               br_phase = read_mode_ff ? PH_ADDR_R : PH_ADDR_W;
            end
         end
         PH_ADDR_W: begin
            if (!read_mode_ff && i10 == 10'd2) begin
               br_taken = 1'b1;
               br_step  = 1'b1;
               br_act   = ACT_DATA;
               br_phase = PH_DATA_TX;
            end
         end
         PH_ADDR_R: begin
            if (read_mode_ff && i10 == 10'd2) begin
               br_taken = 1'b1;
               br_step  = 1'b1;
               br_act   = (n10 == 10'd1) ? ACT_NACK : ACT_ACK;
               br_phase = (n10 == 10'd1) ? PH_RX_NACK : PH_RX_ACK;
            end
         end
         PH_DATA_TX: begin
            if (!read_mode_ff) begin
               if (i10 >= 10'd3 && i10 <= n10 + 10'd1) begin
                  br_taken = 1'b1;
                  br_step  = 1'b1;
                  br_act   = ACT_DATA;
                  br_phase = PH_DATA_TX;
               end else if (i10 == n10 + 10'd2) begin
                  br_taken = 1'b1;
                  br_act   = ACT_STOP;
               end
            end
         end
         PH_RX_ACK: begin
            if (read_mode_ff) begin
               if (i10 >= 10'd3 && i10 <= n10) begin
                  br_taken = 1'b1;
                  br_step  = 1'b1;
                  br_act   = ACT_ACK;
                  br_phase = PH_RX_ACK;
               end else if (i10 == n10 + 10'd1) begin
                  br_taken = 1'b1;
                  br_step  = 1'b1;
                  br_act   = ACT_NACK;
                  br_phase = PH_RX_NACK;
               end
            end
         end
         PH_RX_NACK: begin
            if (read_mode_ff && i10 == n10 + 10'd2) begin
               br_taken = 1'b1;
               br_act   = ACT_STOP;
            end
         end
         default: ;
      endcase

      // with no branch the last action repeats
      act_sel = br_taken ? br_act : last_act_ff;
   end

   // next state
   always_comb begin
      phase_in    = phase_ff;
      index_in    = index_ff;
      error_in    = error_ff;
      status_in   = status_ff;
      stopped_in  = stopped_ff;
      last_act_in = last_act_ff;
      if (fire) begin
         if (item.operation == OP_BEGIN) begin
            phase_in    = PH_START;
            index_in    = 9'd1;
            error_in    = bad_count ? ERR_PARAM : ERR_OK;
            status_in   = ST_NO_INFO;
            stopped_in  = 1'b0;
            last_act_in = ACT_NONE;
         end else if (!match) begin
            status_in  = code;
            error_in   = phase_err;
            stopped_in = 1'b1;
         end else begin
            if (br_taken) begin
               last_act_in = br_act;
            end
            if (br_step) begin
               phase_in = br_phase;
               index_in = index_ff + 9'd1;
            end
            if (error_ff == ERR_OK && act_sel == ACT_STOP) begin
               stopped_in = 1'b1;
            end
         end
      end
   end

   // result fields
   always_comb begin
      result                 = '0;
      result.error_code      = error_in;
      result.captured_status = status_in;
      result.stop_issued     = stopped_in;
      if (item.operation == OP_BEGIN) begin
         result.bus_action = bad_count ? BUS_NONE : BUS_START;
      end else if (!match) begin
         result.bus_action = BUS_STOP;
      end else begin
         if (phase_ff == PH_RX_ACK || phase_ff == PH_RX_NACK) begin
            result.rx_valid = 1'b1;
            result.rx_data  = item.rx_byte;
         end
         if (error_ff == ERR_OK) begin
            case (act_sel)
               ACT_ADDR_W: begin
                  result.bus_action = BUS_LOAD;
                  result.data_out   = {slave_address_ff, 1'b0};
               end
               ACT_ADDR_R: begin
                  result.bus_action = BUS_LOAD;
                  result.data_out   = {slave_address_ff, 1'b1};
               end
               ACT_DATA: begin
                  result.bus_action = BUS_LOAD;
                  result.data_out   = item.tx_byte;
               end
               ACT_ACK:  result.bus_action = BUS_ACK;
               ACT_NACK: result.bus_action = BUS_NACK;
               ACT_STOP: result.bus_action = BUS_STOP;
               default:  result.bus_action = BUS_NONE;
            endcase
         end
      end
   end

endmodule

// ----- hdl/i2cms_rsp_stage.sv -----
// Result register towards the result channel.
module i2cms_rsp_stage
   import i2cms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rsp_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // load while empty or while the held result is taken
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold result payload until taken
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ----- hdl/i2c_master_transaction_sequencer_unit.sv -----
// Top level of the I2C master transaction sequencer.
//
//   channel   direction  handshake      contents
//   req_chan  in         valid/ready    operation, bus_status, rx_byte, tx_byte
//   rsp_chan  out        valid/ready    bus_action, data_out, rx_valid, rx_data,
//                                       error_code, captured_status, stop_issued
//   csr_*     in         write enable   slave_address, byte_count, read_mode
//
// One request per cycle sustained while the result channel is not stalled; a result passes
// through the request register followed by the result register.
// The sequencer state advances when a request moves into the result register.
// Synchronous reset clears slave address and read mode, sets byte count to one, resets the
// sequence state and clears both valid flags. A stalled result channel holds its result;
// requests are still taken until both registers are full.
module i2c_master_transaction_sequencer_unit
   import i2cms_pkg::*;
#(
   parameter int MAX_BYTES = 255
) (
   input  logic        clock,
   input  logic        reset,
   i2cms_req_if.sink   req_chan,
   i2cms_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   req_item_type  req_item, held_item;
   rsp_item_type  core_result, rsp_item;
   csr_write_type csr;
   logic          held_valid;
   logic          fire;
   logic          rsp_load_ready;

   // gather channel and register fields
   assign req_item.operation  = req_chan.operation;
   assign req_item.bus_status = req_chan.bus_status;
   assign req_item.rx_byte    = req_chan.rx_byte;
   assign req_item.tx_byte    = req_chan.tx_byte;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign fire = held_valid && rsp_load_ready;

   i2cms_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_item   (req_item),
      .out_valid (held_valid),
      .out_take  (fire),
      .out_item  (held_item)
   );

   i2cms_seq_core #(
      .MAX_BYTES (MAX_BYTES)
   ) u_seq_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .fire   (fire),
      .item   (held_item),
      .result (core_result)
   );

   i2cms_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_ready  (rsp_load_ready),
      .in_item   (core_result),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_item  (rsp_item)
   );

   // drive result channel fields
   assign rsp_chan.bus_action      = rsp_item.bus_action;
   assign rsp_chan.data_out        = rsp_item.data_out;
   assign rsp_chan.rx_valid        = rsp_item.rx_valid;
   assign rsp_chan.rx_data         = rsp_item.rx_data;
   assign rsp_chan.error_code      = rsp_item.error_code;
   assign rsp_chan.captured_status = rsp_item.captured_status;
   assign rsp_chan.stop_issued     = rsp_item.stop_issued;

endmodule

// ----- hdl/i2cms_checker.sv -----
// Port-level checks on the sequencer result channel, bound to the top level.
module i2cms_checker
   import i2cms_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_bus_action,
   input logic [7:0] rsp_data_out,
   input logic       rsp_rx_valid,
   input logic [7:0] rsp_rx_data,
   input logic [2:0] rsp_error_code,
   input logic [7:0] rsp_captured_status,
   input logic       rsp_stop_issued
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
         && $stable(rsp_bus_action) && $stable(rsp_data_out)
         && $stable(rsp_error_code) && $stable(rsp_stop_issued))
      else $error("result changed while stalled");

   // a stop always marks the transaction finished
   a_stop_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_action == BUS_STOP |-> rsp_stop_issued)
      else $error("stop ordered without stop_issued");

   // a start comes from a clean sequence
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_action == BUS_START |->
         rsp_error_code == ERR_OK && !rsp_stop_issued
         && rsp_captured_status == ST_NO_INFO)
      else $error("start ordered from a dirty sequence");

   // data byte only travels with a load
   a_data_load: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_action != BUS_LOAD |-> rsp_data_out == 8'd0)
      else $error("data_out set without a load");

   // received byte only with its flag
   a_rx_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rx_valid |-> rsp_rx_data == 8'd0)
      else $error("rx_data set without rx_valid");

endmodule

bind i2c_master_transaction_sequencer_unit i2cms_checker u_i2cms_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_bus_action      (rsp_chan.bus_action),
   .rsp_data_out        (rsp_chan.data_out),
   .rsp_rx_valid        (rsp_chan.rx_valid),
   .rsp_rx_data         (rsp_chan.rx_data),
   .rsp_error_code      (rsp_chan.error_code),
   .rsp_captured_status (rsp_chan.captured_status),
   .rsp_stop_issued     (rsp_chan.stop_issued)
);
